// File: src/pvfe_pkg.sv
// ----------------------------------------------------------------------------
// pvfe_pkg
// Shared types and constants of the varint field extractor.
// ----------------------------------------------------------------------------
package pvfe_pkg;

    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int FIELD_W  = 29;
    localparam int STATUS_W = 2;
    localparam int SHIFT_W  = 3;

    // last varint byte index (five bytes max)
    localparam logic [SHIFT_W-1:0] VARINT_LAST_IDX = 3'd4;

    localparam logic [FIELD_W-1:0] TARGET_RESET = 29'd1;

    // wire types
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_FIX32  = 3'd5;

    localparam logic [VALUE_W-1:0] SKIP_FIX64 = 32'd8;
    localparam logic [VALUE_W-1:0] SKIP_FIX32 = 32'd4;

    typedef enum logic [2:0] {
        PH_KEY   = 3'd0,
        PH_VALUE = 3'd1,
        PH_SKIPV = 3'd2,
        PH_SKIPF = 3'd3,
        PH_LEN   = 3'd4,
        PH_SKIPL = 3'd5
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND   = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_BADWIRE = 2'd2,
        ST_TRUNC   = 2'd3
    } status_t;

    typedef struct packed {
        phase_t               phase;
        logic [VALUE_W-1:0]   accum;
        logic [SHIFT_W-1:0]   shift_count;
        logic [VALUE_W-1:0]   skip_left;
        logic                 decided;
    } parse_state_t;

    typedef struct packed {
        logic               valid;
        status_t            status;
        logic [VALUE_W-1:0] value;
    } step_res_t;

    localparam parse_state_t PARSE_CLEAR = '{
        phase:       PH_KEY,
        accum:       '0,
        shift_count: '0,
        skip_left:   '0,
        decided:     1'b0
    };

endpackage

// File: src/pvfe_byte_if.sv
// ----------------------------------------------------------------------------
// pvfe_byte_if
// Message byte channel: one byte per request, last flags the final byte.
// ----------------------------------------------------------------------------
interface pvfe_byte_if;
    import pvfe_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;
    logic              last;

    modport source (output valid, output byte_in, output last, input ready);
    modport sink   (input valid, input byte_in, input last, output ready);

endinterface

// File: src/pvfe_status_if.sv
// ----------------------------------------------------------------------------
// pvfe_status_if
// Result channel: one status request per message.
// ----------------------------------------------------------------------------
interface pvfe_status_if;
    import pvfe_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, output status, output value, input ready);
    modport sink   (input valid, input status, input value, output ready);

endinterface

// File: src/pvfe_cfg_if.sv
// ----------------------------------------------------------------------------
// pvfe_cfg_if
// Configuration write channel for the target field number.
// ----------------------------------------------------------------------------
interface pvfe_cfg_if;
    import pvfe_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] target_field;

    modport source (output valid, output target_field, input ready);
    modport sink   (input valid, input target_field, output ready);

endinterface

// File: src/pvfe_step.sv
// ----------------------------------------------------------------------------
// pvfe_step
// One parser step: consumes one byte, returns next state and any result.
// ----------------------------------------------------------------------------
module pvfe_step (
    input  pvfe_pkg::parse_state_t             cur,
    input  logic [pvfe_pkg::BYTE_W-1:0]        byte_in,
    input  logic                               last,
    input  logic [pvfe_pkg::FIELD_W-1:0]       target_field,
    output pvfe_pkg::parse_state_t             nxt,
    output pvfe_pkg::step_res_t                res
);
    import pvfe_pkg::*;

    logic [VALUE_W-1:0] part;
    logic [VALUE_W-1:0] vacc;
    logic               vdone;
    logic               vover;
    logic [VALUE_W-1:0] skip_dec;
    logic [2:0]         key_wt;

    // 7-bit group placed by byte index; fifth byte keeps only 4 bits
    always_comb
    begin
        case (cur.shift_count)
            3'd0:    part = {25'b0, byte_in[6:0]};
            3'd1:    part = {18'b0, byte_in[6:0], 7'b0};
            3'd2:    part = {11'b0, byte_in[6:0], 14'b0};
            3'd3:    part = {4'b0, byte_in[6:0], 21'b0};
            default: part = {byte_in[3:0], 28'b0};
        endcase
    end

    assign vacc      = cur.accum | part;
    assign vdone     = ~byte_in[7];
    assign vover     = byte_in[7] && (cur.shift_count >= VARINT_LAST_IDX);
    assign key_wt    = vacc[2:0];
    assign skip_dec  = (cur.skip_left != '0) ? (cur.skip_left - 32'd1) : cur.skip_left;

    always_comb
    begin
        nxt = cur;
        res = '{valid: 1'b0, status: ST_FOUND, value: '0};

        if (!cur.decided)
        begin
            case (cur.phase)
                PH_KEY, PH_VALUE, PH_SKIPV, PH_LEN:
                begin
                    nxt.accum = vacc;
                    if (!vdone && !vover)
                        nxt.shift_count = cur.shift_count + 3'd1;

                    if (vover)
                    begin
                        res.valid  = 1'b1;
                        res.status = ST_TRUNC;
                    end
                    else if (vdone)
                    begin
                        case (cur.phase)
                            PH_KEY:
                            begin
                                nxt.accum       = '0;
                                nxt.shift_count = '0;
                                if (key_wt == WT_VARINT && vacc[31:3] == target_field)
                                    nxt.phase = PH_VALUE;
                                else if (key_wt == WT_VARINT)
                                    nxt.phase = PH_SKIPV;
                                else if (key_wt == WT_FIX64)
                                begin
                                    // key accum kept until skip ends, as a plain copy
                                    nxt.accum       = vacc;
                                    nxt.shift_count = cur.shift_count;
                                    nxt.phase       = PH_SKIPF;
                                    nxt.skip_left   = SKIP_FIX64;
                                end
                                else if (key_wt == WT_FIX32)
                                begin
                                    nxt.accum       = vacc;
                                    nxt.shift_count = cur.shift_count;
                                    nxt.phase       = PH_SKIPF;
                                    nxt.skip_left   = SKIP_FIX32;
                                end
                                else if (key_wt == WT_LEN)
                                    nxt.phase = PH_LEN;
                                else
                                begin
                                    nxt.accum       = vacc;
                                    nxt.shift_count = cur.shift_count;
                                    res.valid       = 1'b1;
                                    res.status      = ST_BADWIRE;
                                end
                            end
                            PH_VALUE:
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_FOUND;
                                res.value  = vacc;
                            end
                            PH_SKIPV:
                            begin
                                nxt.phase       = PH_KEY;
                                nxt.accum       = '0;
                                nxt.shift_count = '0;
                            end
                            default: // length prefix done
                            begin
                                nxt.skip_left = vacc;
                                if (vacc == '0)
                                begin
                                    nxt.phase       = PH_KEY;
                                    nxt.accum       = '0;
                                    nxt.shift_count = '0;
                                end
                                else
                                    nxt.phase = PH_SKIPL;
                            end
                        endcase
                    end
                end
                default: // fixed or length-delimited skip
                begin
                    nxt.skip_left = skip_dec;
                    if (skip_dec == '0)
                    begin
                        nxt.phase       = PH_KEY;
                        nxt.accum       = '0;
                        nxt.shift_count = '0;
                    end
                end
            endcase

            if (!res.valid && last)
            begin
                res.valid = 1'b1;
                if (nxt.phase == PH_KEY && nxt.shift_count == '0 && nxt.accum == '0)
                    res.status = ST_ABSENT;
                else
                    res.status = ST_TRUNC;
            end

            if (res.valid)
                nxt.decided = 1'b1;
        end

        if (last)
            nxt = PARSE_CLEAR;
    end

endmodule

// File: src/protobuf_varint_field_extractor_unit.sv
// ----------------------------------------------------------------------------
// protobuf_varint_field_extractor_unit
// Streams a protobuf message and extracts one varint field by number.
// ----------------------------------------------------------------------------
// Usage:
//   msg    - byte requests; last marks the final byte of a message.
//   result - one request per message: status (found, absent, bad wire type,
//            truncated/overlong) and value (the field value when found).
//   cfg    - writes target_field; write only while the block is idle.
// Timing:
//   A byte is parsed during the cycle it sits in the input register; its
//   result, if any, then passes into the output register once that is free.
//   One byte per cycle unless a result stalls: the parser step is one
//   pass of shift/mask/compare logic plus a 32-bit skip counter decrement.
// Stalls:
//   A byte without a result proceeds even if result is stalled; a byte that
//   produces a result waits in the input register until the output register
//   frees, and msg.ready drops then.
// Reset:
//   Parser returns to key state, target_field goes to 1, both registers empty.
// After a decision further bytes are dropped until last, which resets the
// parser for the next message.
// ----------------------------------------------------------------------------
module protobuf_varint_field_extractor_unit (
    input  logic               clk,
    input  logic               rst_n,
    pvfe_byte_if.sink          msg,
    pvfe_status_if.source      result,
    pvfe_cfg_if.sink           cfg
);
    import pvfe_pkg::*;

    // input stage
    logic                msg_valid_reg;
    logic [BYTE_W-1:0]   msg_byte_reg;
    logic                msg_last_reg;

    // parser state and config
    parse_state_t        state_reg;
    parse_state_t        state_next;
    logic [FIELD_W-1:0]  target_reg;

    // output stage
    logic                res_valid_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [VALUE_W-1:0]  res_value_reg;

    step_res_t           step_res;
    logic                out_free;
    logic                step_go;

    pvfe_step u_step (
        .cur          (state_reg),
        .byte_in      (msg_byte_reg),
        .last         (msg_last_reg),
        .target_field (target_reg),
        .nxt          (state_next),
        .res          (step_res)
    );

    // output register drains this cycle or is empty
    assign out_free = !res_valid_reg || result.ready;
    // a byte with no result never waits on the output side
    assign step_go  = msg_valid_reg && (!step_res.valid || out_free);

    assign msg.ready     = !msg_valid_reg || step_go;
    assign cfg.ready     = 1'b1;
    assign result.valid  = res_valid_reg;
    assign result.status = res_status_reg;
    assign result.value  = res_value_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            msg_valid_reg <= 1'b0;
        else if (msg.ready)
            msg_valid_reg <= msg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (msg.valid && msg.ready)
        begin
            msg_byte_reg <= msg.byte_in;
            msg_last_reg <= msg.last;
        end
    end

    // parser state and target register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= PARSE_CLEAR;
            target_reg <= TARGET_RESET;
        end
        else
        begin
            if (step_go)
                state_reg <= state_next;
            if (cfg.valid && cfg.ready)
                target_reg <= cfg.target_field;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (step_go && step_res.valid)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_go && step_res.valid)
        begin
            res_status_reg <= step_res.status;
            res_value_reg  <= step_res.value;
        end
    end

    // ---------------------------------------------------------------- checks

    // varint byte index never passes the fifth byte
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.shift_count <= VARINT_LAST_IDX)
        else $error("varint byte index out of range");

    // a result inside a message freezes the parser until last
    assert property (@(posedge clk) disable iff (!rst_n)
        step_go && step_res.valid && !msg_last_reg |=> state_reg.decided)
        else $error("decision not recorded");

    // the final byte always returns the parser to a clean key state
    assert property (@(posedge clk) disable iff (!rst_n)
        step_go && msg_last_reg |=>
            !state_reg.decided && state_reg.phase == PH_KEY &&
            state_reg.shift_count == '0 && state_reg.accum == '0)
        else $error("parser not cleared at message end");

    // value is zero unless the field was found
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_status_reg != ST_FOUND |-> res_value_reg == '0)
        else $error("nonzero value on non-found status");

endmodule

// File: test/pvfe_field_checker.sv
// ----------------------------------------------------------------------------
// pvfe_field_checker
// Watches the byte, result and configuration channels of the varint field
// extractor, predicts one status per message and compares every result.
// ----------------------------------------------------------------------------
module pvfe_field_checker (
    input  logic        clk,
    input  logic        rst_n,
    pvfe_byte_if        msg,
    pvfe_status_if      result,
    pvfe_cfg_if         cfg,
    output int unsigned outstanding,
    output int          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import pvfe_pkg::*;

    typedef enum logic [1:0] {
        VB_MORE,
        VB_DONE,
        VB_OVER
    } varint_step_t;

    typedef struct packed {
        status_t            st;
        logic [VALUE_W-1:0] val;
    } status_rec_t;

    status_rec_t        status_q[$];

    // predicted parser state
    logic [FIELD_W-1:0] tgt;
    phase_t             ph;
    logic [VALUE_W-1:0] acc;
    logic [SHIFT_W-1:0] cnt;
    logic [VALUE_W-1:0] skip_cnt;
    logic               done_msg;

    function automatic void restart(input phase_t p);
        ph  = p;
        acc = '0;
        cnt = '0;
    endfunction

    function automatic void clear_msg();
        restart(PH_KEY);
        skip_cnt = '0;
        done_msg = 1'b0;
    endfunction

    // one varint byte; bits past 32 fall off the top
    function automatic varint_step_t absorb(input logic [BYTE_W-1:0] b);
        logic [63:0] part;
        part = 64'(b[6:0]) << (7 * cnt);
        acc  = acc | part[31:0];
        if (!b[7])
            return VB_DONE;
        if (cnt >= VARINT_LAST_IDX)
            return VB_OVER;
        cnt = cnt + 1'b1;
        return VB_MORE;
    endfunction

    task automatic flag_mismatch(input string what);
        fail_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic fin);
        varint_step_t r;
        bit           hit;
        status_t      st;
        logic [VALUE_W-1:0] val;
        hit = 1'b0;
        st  = ST_FOUND;
        val = '0;
        if (!done_msg) begin
            case (ph)
                PH_KEY: begin
                    r = absorb(b);
                    if (r == VB_OVER) begin
                        hit = 1'b1;
                        st  = ST_TRUNC;
                    end
                    else if (r == VB_DONE) begin
                        if (acc[2:0] == WT_VARINT && acc[31:3] == tgt)
                            restart(PH_VALUE);
                        else if (acc[2:0] == WT_VARINT)
                            restart(PH_SKIPV);
                        else if (acc[2:0] == WT_FIX64) begin
                            ph       = PH_SKIPF;
                            skip_cnt = SKIP_FIX64;
                        end
                        else if (acc[2:0] == WT_FIX32) begin
                            ph       = PH_SKIPF;
                            skip_cnt = SKIP_FIX32;
                        end
                        else if (acc[2:0] == WT_LEN)
                            restart(PH_LEN);
                        else begin
                            hit = 1'b1;
                            st  = ST_BADWIRE;
                        end
                    end
                end
                PH_VALUE: begin
                    r = absorb(b);
                    if (r == VB_OVER) begin
                        hit = 1'b1;
                        st  = ST_TRUNC;
                    end
                    else if (r == VB_DONE) begin
                        hit = 1'b1;
                        st  = ST_FOUND;
                        val = acc;
                    end
                end
                PH_SKIPV: begin
                    r = absorb(b);
                    if (r == VB_OVER) begin
                        hit = 1'b1;
                        st  = ST_TRUNC;
                    end
                    else if (r == VB_DONE)
                        restart(PH_KEY);
                end
                PH_LEN: begin
                    r = absorb(b);
                    if (r == VB_OVER) begin
                        hit = 1'b1;
                        st  = ST_TRUNC;
                    end
                    else if (r == VB_DONE) begin
                        skip_cnt = acc;
                        if (skip_cnt == 0)
                            restart(PH_KEY);
                        else
                            ph = PH_SKIPL;
                    end
                end
                default: begin
                    if (skip_cnt != 0)
                        skip_cnt = skip_cnt - 1;
                    if (skip_cnt == 0)
                        restart(PH_KEY);
                end
            endcase
            // clean end only at a key boundary with nothing gathered
            if (!hit && fin) begin
                hit = 1'b1;
                st  = (ph == PH_KEY && cnt == 0 && acc == 0) ? ST_ABSENT : ST_TRUNC;
            end
            if (hit)
                done_msg = 1'b1;
        end
        if (hit)
            status_q.push_back('{st: st, val: (st == ST_FOUND) ? val : '0});
        if (fin)
            clear_msg();
    endtask

    task automatic check_result(input logic [STATUS_W-1:0] st, input logic [VALUE_W-1:0] val);
        status_rec_t exp_rec;
        if (status_q.size() == 0) begin
            flag_mismatch($sformatf("status %0d value 0x%08h with none pending", st, val));
            return;
        end
        exp_rec = status_q.pop_front();
        if (st !== exp_rec.st)
            flag_mismatch($sformatf("status %0d, expected %0d", st, exp_rec.st));
        if (val !== exp_rec.val)
            flag_mismatch($sformatf("value 0x%08h, expected 0x%08h", val, exp_rec.val));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tgt = TARGET_RESET;
            clear_msg();
            status_q.delete();
            fail_count  = 0;
            outstanding <= 0;
        end
        else begin
            if (cfg.valid && cfg.ready)
                tgt = cfg.target_field;
            if (msg.valid && msg.ready)
                parse_byte(msg.byte_in, msg.last);
            if (result.valid && result.ready)
                check_result(result.status, result.value);
            outstanding <= status_q.size();
        end
    end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the protobuf varint field extractor: directed messages for
// each wire type, boundary and truncation, then random messages under
// several target fields, with random stalls on both channels. A checker
// beside the block predicts and compares each status request.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pvfe_pkg::*;

    // wire types the block rejects
    localparam logic [2:0] WT_SGROUP = 3'd3;
    localparam logic [2:0] WT_EGROUP = 3'd4;
    localparam logic [2:0] WT_RSVD6  = 3'd6;
    localparam logic [2:0] WT_RSVD7  = 3'd7;

    localparam logic [FIELD_W-1:0] FIELD_MAX = 29'h1FFF_FFFF;

    logic clk;
    logic rst_n;

    pvfe_byte_if   msg_if ();
    pvfe_status_if res_if ();
    pvfe_cfg_if    cfg_if ();

    int unsigned outstanding;
    int          fail_count;

    // bytes of the message being built, sent front to back
    logic [BYTE_W-1:0]  frame[$];
    int                 bytes_sent;
    bit                 idle_en;
    logic [FIELD_W-1:0] cur_target;
    int                 stall_left;

    protobuf_varint_field_extractor_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    pvfe_field_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg         (msg_if),
        .result      (res_if),
        .cfg         (cfg_if),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Result side back-pressure: ready drops at random while idling is on
    // and comes back when the stall count runs out, even if idling stops.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left   <= 0;
            res_if.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
                res_if.ready <= 1'b1;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            stall_left   <= $urandom_range(1, 7);
            res_if.ready <= 1'b0;
        end
    end

    // Varint encoder. pad adds redundant zero groups (capped at five
    // bytes); junk fills the unused top bits of a fifth byte, which the
    // block must drop.
    function automatic void push_varint(input logic [31:0] v, input int pad, input bit junk);
        int         n;
        int         len;
        logic [6:0] grp;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 0)
            n++;
        len = n + pad;
        if (len > 5)
            len = 5;
        for (int i = 0; i < len; i++)
        begin
            grp = 7'(v >> (7 * i));
            if (i == 4 && junk)
                grp[6:4] = 3'($urandom);
            frame.push_back({i < len - 1, grp});
        end
    endfunction

    function automatic void push_key(input logic [FIELD_W-1:0] field, input logic [2:0] wt);
        push_varint({field, wt}, 0, 1'b0);
    endfunction

    function automatic void push_random(input int n);
        repeat (n)
            frame.push_back(8'($urandom));
    endfunction

    // Mostly the target and its neighbor so that matches and near misses
    // both occur; the rest are fields 0..31 or anywhere in the field range.
    function automatic logic [FIELD_W-1:0] pick_field();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return cur_target;
        if (r < 6)
            return cur_target + 1'b1;
        if (r < 8)
            return FIELD_W'($urandom_range(0, 31));
        return FIELD_W'($urandom);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return $urandom_range(1, 127);
            2:       return $urandom_range(128, 16383);
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // One byte request; an optional idle burst goes first. valid stays
    // high after the accept so back-to-back bytes have no bubble.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            msg_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        msg_if.valid   <= 1'b1;
        msg_if.byte_in <= b;
        msg_if.last    <= fin;
        @(posedge clk);
        while (!msg_if.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
        frame.delete();
    endtask

    // Target writes only with the parser idle: the byte channel is
    // dropped, every predicted status has drained, and a few more cycles
    // cover a final byte that produced no request.
    task automatic set_target(input logic [FIELD_W-1:0] v);
        msg_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_if.valid        <= 1'b1;
        cfg_if.target_field <= v;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        cur_target = v;
    endtask

    // Random message: fields of every wire type with random content, some
    // overlong, sometimes cut short; one in ten is plain noise.
    task automatic random_message();
        int         nf;
        int         cut;
        logic [2:0] wt;
        logic [31:0] len;
        frame.delete();
        if ($urandom_range(0, 9) == 0)
            push_random($urandom_range(1, 6));
        else
        begin
            nf = $urandom_range(1, 4);
            repeat (nf)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4:
                    begin
                        push_key(pick_field(), WT_VARINT);
                        push_varint(pick_value(),
                                    ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0,
                                    $urandom_range(0, 1));
                    end
                    5, 6:
                    begin
                        push_key(cur_target, WT_VARINT);
                        push_varint(pick_value(), 0, 1'b1);
                    end
                    7, 8, 9:
                    begin
                        push_key(pick_field(), WT_FIX64);
                        push_random(8);
                    end
                    10, 11, 12:
                    begin
                        push_key(pick_field(), WT_FIX32);
                        push_random(4);
                    end
                    13, 14, 15, 16:
                    begin
                        len = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 30)
                                                          : $urandom_range(0, 5);
                        push_key(pick_field(), WT_LEN);
                        push_varint(len, ($urandom_range(0, 5) == 0) ? 1 : 0, 1'b0);
                        push_random(len);
                    end
                    17:
                    begin
                        case ($urandom_range(0, 3))
                            0:       wt = WT_SGROUP;
                            1:       wt = WT_EGROUP;
                            2:       wt = WT_RSVD6;
                            default: wt = WT_RSVD7;
                        endcase
                        push_key(pick_field(), wt);
                        push_random($urandom_range(0, 2));
                    end
                    default:
                    begin
                        // six-byte varint: fifth byte still continues
                        push_key(pick_field(), WT_VARINT);
                        repeat (5)
                            frame.push_back(8'h80 | 8'($urandom));
                        push_random(1);
                    end
                endcase
            end
            if ($urandom_range(0, 7) == 0 && frame.size() > 1)
            begin
                cut = $urandom_range(1, frame.size() - 1);
                repeat (cut)
                    void'(frame.pop_back());
            end
        end
        send_frame();
    endtask

    // Guard against a hung handshake or a status that never comes.
    initial
    begin
        #3_000_000;
        $display("protobuf_varint_field_extractor_unit test failed");
        $finish;
    end

    initial
    begin
        int stop_at;

        rst_n               = 1'b0;
        idle_en             = 1'b1;
        bytes_sent          = 0;
        cur_target          = TARGET_RESET;
        msg_if.valid        <= 1'b0;
        msg_if.byte_in      <= '0;
        msg_if.last         <= 1'b0;
        cfg_if.valid        <= 1'b0;
        cfg_if.target_field <= TARGET_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed, target at its reset value of 1 ----

        // found: zero, then all ones with junk in the fifth byte's top bits
        push_key(1, WT_VARINT);
        push_varint(32'd0, 0, 1'b0);
        send_frame();
        push_key(1, WT_VARINT);
        frame.push_back(8'hFF);
        frame.push_back(8'hFF);
        frame.push_back(8'hFF);
        frame.push_back(8'hFF);
        frame.push_back(8'h7F);
        send_frame();

        // overlong value; the bytes after the decision, last too, are dropped
        push_key(1, WT_VARINT);
        repeat (5)
            frame.push_back(8'h80);
        frame.push_back(8'h01);
        send_frame();

        // skipped wire types ahead of the match: fixed64, fixed32,
        // length run with a padded prefix, zero-length run
        push_key(2, WT_FIX64);
        push_random(8);
        push_key(3, WT_FIX32);
        push_random(4);
        push_key(4, WT_LEN);
        push_varint(32'd3, 1, 1'b0);
        push_random(3);
        push_key(5, WT_LEN);
        push_varint(32'd0, 0, 1'b0);
        push_key(1, WT_VARINT);
        push_varint(32'd42, 0, 1'b0);
        send_frame();

        // clean end without the field
        push_key(2, WT_VARINT);
        push_varint(32'd5, 0, 1'b0);
        send_frame();

        // rejected wire types, one with trailing bytes
        push_key(1, WT_SGROUP);
        send_frame();
        push_key(1, WT_EGROUP);
        send_frame();
        push_key(1, WT_RSVD6);
        send_frame();
        push_key(1, WT_RSVD7);
        push_random(1);
        send_frame();

        // early ends: after a key, inside a value, inside a key,
        // with fixed bytes left, with run bytes left
        push_key(1, WT_VARINT);
        send_frame();
        push_key(1, WT_VARINT);
        frame.push_back(8'h80);
        send_frame();
        frame.push_back(8'h88);
        send_frame();
        push_key(2, WT_FIX64);
        push_random(2);
        send_frame();
        push_key(2, WT_LEN);
        push_varint(32'd5, 0, 1'b0);
        push_random(1);
        send_frame();

        // largest field number, five-byte key, no match
        push_key(FIELD_MAX, WT_VARINT);
        push_varint(32'd1, 0, 1'b0);
        send_frame();

        // target zero: key 0 with wire type 0 matches
        set_target('0);
        push_key(0, WT_VARINT);
        push_varint(32'd7, 0, 1'b0);
        send_frame();

        // largest target
        set_target(FIELD_MAX);
        push_key(FIELD_MAX, WT_VARINT);
        push_varint(32'd129, 0, 1'b0);
        send_frame();

        // ---- random phases, one target each; the final one runs
        // without idling on either side ----
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:       set_target(FIELD_W'($urandom_range(1, 15)));
                1:       set_target(FIELD_W'($urandom_range(1, FIELD_MAX)));
                2:       set_target(FIELD_MAX);
                3:       set_target(TARGET_RESET);
                4:       set_target(FIELD_W'($urandom_range(1, 40)));
                default: set_target(FIELD_W'($urandom_range(1, FIELD_MAX)));
            endcase
            idle_en = (p == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
            stop_at = bytes_sent + 60;
            while (bytes_sent < stop_at)
                random_message();
        end

        // drain: every status back, then a quiet wait before the verdict
        msg_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("protobuf_varint_field_extractor_unit test passed");
        else
            $display("protobuf_varint_field_extractor_unit test failed");
        $finish;
    end

endmodule

// File: sim.f
src/pvfe_pkg.sv
src/pvfe_byte_if.sv
src/pvfe_status_if.sv
src/pvfe_cfg_if.sv
src/pvfe_step.sv
src/protobuf_varint_field_extractor_unit.sv
test/pvfe_field_checker.sv
test/tb_top.sv
